// ----- hdl/snfcs_pkg.sv -----
package snfcs_pkg;

   localparam int PAGE_BYTES_DEFAULT   = 256;
   localparam int ADDRESS_BITS_DEFAULT = 24;

   localparam logic [11:0] POLL_LIMIT_RESET    = 12'd3000;
   localparam logic [7:0]  POLL_INTERVAL_RESET = 8'd10;

   typedef enum logic [1:0] {
      OPER_REQUEST  = 2'd0,
      OPER_HOST     = 2'd1,
      OPER_RESPONSE = 2'd2,
      OPER_TICK     = 2'd3
   } oper_type;

   localparam logic [2:0] CMD_READ   = 3'd0;
   localparam logic [2:0] CMD_WRITE  = 3'd1;
   localparam logic [2:0] CMD_SECTOR = 3'd2;
   localparam logic [2:0] CMD_CHIP   = 3'd3;
   localparam logic [2:0] CMD_PDOWN  = 3'd4;
   localparam logic [2:0] CMD_WAKE   = 3'd5;

   localparam logic [7:0] OP_READ    = 8'h03;
   localparam logic [7:0] OP_PROGRAM = 8'h02;
   localparam logic [7:0] OP_WREN    = 8'h06;
   localparam logic [7:0] OP_RDSR    = 8'h05;
   localparam logic [7:0] OP_SECTOR  = 8'h20;
   localparam logic [7:0] OP_CHIP    = 8'hC7;
   localparam logic [7:0] OP_PDOWN   = 8'hB9;
   localparam logic [7:0] OP_WAKE    = 8'hAB;
   localparam logic [7:0] DUMMY_BYTE = 8'hFF;

   localparam logic [1:0] GOAL_PRE  = 2'd0;
   localparam logic [1:0] GOAL_WREN = 2'd1;
   localparam logic [1:0] GOAL_POST = 2'd2;

   localparam logic CSR_POLL_LIMIT    = 1'b0;
   localparam logic CSR_POLL_INTERVAL = 1'b1;

   typedef struct packed {
      logic [1:0]  operation;
      logic [2:0]  command;
      logic [23:0] flash_address;
      logic [15:0] byte_count;
      logic [7:0]  host_byte;
      logic [7:0]  response_byte;
   } item_type;

   typedef struct packed {
      logic       spi_valid;
      logic [7:0] spi_out_byte;
      logic       frame_end;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       need_host_byte;
      logic       request_done;
      logic       timed_out;
   } result_type;

endpackage

// ----- hdl/spi_nor_flash_command_sequencer_core.sv -----
// Streaming SPI NOR command sequencer. Each req item (request, host write byte,
// SPI response byte or tick) is held in the input register and yields at
// most one rsp item, which the engine loads into the result register when it
// advances. req_tready drops only while the input register holds an item and the
// rsp item ahead of it is stalled; otherwise items flow back to back at one per cycle.
// Every rsp carrying spi_valid expects one response item back. req_tuser carries
// the operation, req_tdata command, flash_address, byte_count, host_byte and
// response_byte from bit 0 up.
module spi_nor_flash_command_sequencer_core #(
   parameter int PAGE_BYTES   = snfcs_pkg::PAGE_BYTES_DEFAULT,
   parameter int ADDRESS_BITS = snfcs_pkg::ADDRESS_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // command, flash_address, byte_count, host_byte,
                                    // response_byte, zero fill
   input  logic [1:0]  req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // spi_valid, spi_out_byte, frame_end, read_valid,
                                    // read_byte, need_host_byte, request_done, timed_out
   output logic        rsp_tlast,   // last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [11:0] csr_data
);
   logic                  in_valid_ff;
   snfcs_pkg::item_type   in_ff;
   logic [11:0]           limit_ff;
   logic [7:0]            interval_ff;
   logic                  res_valid;
   snfcs_pkg::result_type res;
   logic                  advance;

   // the engine moves on whenever its result register is empty or draining
   assign advance    = !res_valid || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         limit_ff    <= snfcs_pkg::POLL_LIMIT_RESET;
         interval_ff <= snfcs_pkg::POLL_INTERVAL_RESET;
      end else begin
         in_valid_ff <= (req_tvalid && req_tready) || (in_valid_ff && !advance);
         if (csr_valid && csr_index == snfcs_pkg::CSR_POLL_LIMIT) limit_ff <= csr_data;
         if (csr_valid && csr_index == snfcs_pkg::CSR_POLL_INTERVAL)
            interval_ff <= csr_data[7:0];
      end
      if (req_tvalid && req_tready) begin
         in_ff.operation     <= req_tuser;
         in_ff.command       <= req_tdata[2:0];
         in_ff.flash_address <= req_tdata[26:3];
         in_ff.byte_count    <= req_tdata[42:27];
         in_ff.host_byte     <= req_tdata[50:43];
         in_ff.response_byte <= req_tdata[58:51];
      end
   end

   snfcs_engine #(.PAGE_BYTES(PAGE_BYTES), .ADDRESS_BITS(ADDRESS_BITS)) u_engine (
      .clock(clock), .reset(reset), .advance(advance),
      .item_valid(in_valid_ff), .item(in_ff),
      .poll_limit(limit_ff), .poll_interval(interval_ff),
      .result_valid(res_valid), .result(res)
   );

   assign rsp_tvalid = res_valid;
   assign rsp_tlast  = 1'b1;
   assign rsp_tdata  = {2'b00, res.timed_out, res.request_done, res.need_host_byte,
                        res.read_byte, res.read_valid, res.frame_end,
                        res.spi_out_byte, res.spi_valid};

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp item dropped");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] || rsp_tdata[10] || rsp_tdata[19] ||
                      rsp_tdata[20] || rsp_tdata[21]))
      else $error("empty rsp item");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp item changed while stalled");
endmodule

// ----- hdl/snfcs_engine.sv -----
module snfcs_engine #(
   parameter int PAGE_BYTES   = snfcs_pkg::PAGE_BYTES_DEFAULT,
   parameter int ADDRESS_BITS = snfcs_pkg::ADDRESS_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   item_valid,
   input  snfcs_pkg::item_type    item,
   input  logic [11:0]            poll_limit,
   input  logic [7:0]             poll_interval,
   output logic                   result_valid,
   output snfcs_pkg::result_type  result
);
   localparam int ADDR_BYTES = (ADDRESS_BITS + 7) / 8;
   localparam int PAGE_W     = $clog2(PAGE_BYTES);

   typedef enum logic [3:0] {
      PH_IDLE, PH_SR_CMD, PH_SR_DATA, PH_DELAY, PH_WREN,
      PH_OPCODE, PH_ADDR, PH_RDATA, PH_HOST, PH_WDATA
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [2:0]              cmd_ff, cmd_in;
   logic [ADDRESS_BITS-1:0] cur_ff, cur_in;
   logic [15:0]             left_ff, left_in;
   logic [PAGE_W:0]         page_ff, page_in;
   logic [1:0]              hidx_ff, hidx_in;
   logic [11:0]             poll_ff, poll_in;
   logic [7:0]              tick_ff, tick_in;
   snfcs_pkg::result_type   r;

   // bytes to the end of the page, clipped by what is left
   function automatic logic [PAGE_W:0] plan(input logic [ADDRESS_BITS-1:0] a,
                                            input logic [15:0] n);
      logic [PAGE_W:0] room;
      room = (PAGE_W+1)'(PAGE_BYTES) - {1'b0, a[PAGE_W-1:0]};
      plan = ({{(16-PAGE_W-1){1'b0}}, room} > n) ? n[PAGE_W:0] : room;
   endfunction

   function automatic logic [7:0] addr_byte(input logic [ADDRESS_BITS-1:0] a,
                                            input logic [1:0] i);
      logic [8*ADDR_BYTES-1:0] w;
      w = (8*ADDR_BYTES)'(a);
      addr_byte = w[8*(ADDR_BYTES-1-32'(i)) +: 8];
   endfunction

   always_comb begin
      logic follows;
      logic last_hdr;
      phase_in = phase_ff; cmd_in = cmd_ff; cur_in = cur_ff; left_in = left_ff;
      page_in = page_ff; hidx_in = hidx_ff; poll_in = poll_ff; tick_in = tick_ff;
      r = '0;
      follows = 1'b0;
      last_hdr = 1'b0;
      if (item_valid) begin
         case (item.operation)
            snfcs_pkg::OPER_REQUEST: begin
               if (phase_ff == PH_IDLE && item.command <= snfcs_pkg::CMD_WAKE) begin
                  cmd_in  = item.command;
                  cur_in  = ADDRESS_BITS'(item.flash_address);
                  left_in = item.byte_count;
                  r.spi_valid = 1'b1;
                  if (item.command == snfcs_pkg::CMD_PDOWN ||
                      item.command == snfcs_pkg::CMD_WAKE) begin
                     phase_in = PH_OPCODE;
                     r.spi_out_byte = (item.command == snfcs_pkg::CMD_PDOWN) ?
                                      snfcs_pkg::OP_PDOWN : snfcs_pkg::OP_WAKE;
                     r.frame_end = 1'b1;
                  end else begin
                     if (item.command == snfcs_pkg::CMD_WRITE)
                        page_in = plan(ADDRESS_BITS'(item.flash_address),
                                       item.byte_count);
                     poll_in = '0; tick_in = '0; hidx_in = snfcs_pkg::GOAL_PRE;
                     phase_in = PH_SR_CMD;
                     r.spi_out_byte = snfcs_pkg::OP_RDSR;
                  end
               end
            end
            snfcs_pkg::OPER_HOST: begin
               if (phase_ff == PH_HOST) begin
                  phase_in = PH_WDATA;
                  r.spi_valid = 1'b1;
                  r.spi_out_byte = item.host_byte;
                  r.frame_end = (page_ff == (PAGE_W+1)'(1));
               end
            end
            snfcs_pkg::OPER_TICK: begin
               if (phase_ff == PH_DELAY) begin
                  tick_in = (tick_ff != 8'hFF) ? tick_ff + 8'd1 : tick_ff;
                  if (tick_in >= poll_interval) begin
                     phase_in = PH_SR_CMD;
                     r.spi_valid = 1'b1;
                     r.spi_out_byte = snfcs_pkg::OP_RDSR;
                  end
               end
            end
            default: begin
               unique case (phase_ff)
                  PH_SR_CMD: begin
                     phase_in = PH_SR_DATA;
                     r.spi_valid = 1'b1;
                     r.spi_out_byte = snfcs_pkg::DUMMY_BYTE;
                     r.frame_end = 1'b1;
                  end
                  PH_SR_DATA: begin
                     if (item.response_byte[0] && poll_ff < poll_limit) begin
                        poll_in = poll_ff + 12'd1;
                        tick_in = '0;
                        if (poll_interval == 8'd0) begin
                           phase_in = PH_SR_CMD;
                           r.spi_valid = 1'b1;
                           r.spi_out_byte = snfcs_pkg::OP_RDSR;
                        end else begin
                           phase_in = PH_DELAY;
                        end
                     end else begin
                        r.timed_out = item.response_byte[0];
                        // continue with the step that follows the wait
                        if (hidx_ff == snfcs_pkg::GOAL_PRE) begin
                           r.spi_valid = 1'b1;
                           if (cmd_ff == snfcs_pkg::CMD_READ) begin
                              phase_in = PH_OPCODE;
                              r.spi_out_byte = snfcs_pkg::OP_READ;
                           end else begin
                              phase_in = PH_WREN;
                              r.spi_out_byte = snfcs_pkg::OP_WREN;
                              r.frame_end = 1'b1;
                           end
                        end else if (hidx_ff == snfcs_pkg::GOAL_WREN) begin
                           phase_in = PH_OPCODE;
                           r.spi_valid = 1'b1;
                           if (cmd_ff == snfcs_pkg::CMD_WRITE)
                              r.spi_out_byte = snfcs_pkg::OP_PROGRAM;
                           else if (cmd_ff == snfcs_pkg::CMD_SECTOR)
                              r.spi_out_byte = snfcs_pkg::OP_SECTOR;
                           else begin
                              r.spi_out_byte = snfcs_pkg::OP_CHIP;
                              r.frame_end = 1'b1;
                           end
                        end else if (cmd_ff == snfcs_pkg::CMD_WRITE && left_ff != 16'd0) begin
                           page_in = plan(cur_ff, left_ff);
                           poll_in = '0; tick_in = '0; hidx_in = snfcs_pkg::GOAL_PRE;
                           phase_in = PH_SR_CMD;
                           r.spi_valid = 1'b1;
                           r.spi_out_byte = snfcs_pkg::OP_RDSR;
                        end else begin
                           phase_in = PH_IDLE;
                           r.request_done = 1'b1;
                        end
                     end
                  end
                  PH_WREN: begin
                     poll_in = '0; tick_in = '0; hidx_in = snfcs_pkg::GOAL_WREN;
                     phase_in = PH_SR_CMD;
                     r.spi_valid = 1'b1;
                     r.spi_out_byte = snfcs_pkg::OP_RDSR;
                  end
                  PH_OPCODE, PH_ADDR: begin
                     if (phase_ff == PH_OPCODE && cmd_ff == snfcs_pkg::CMD_CHIP) begin
                        poll_in = '0; tick_in = '0; hidx_in = snfcs_pkg::GOAL_POST;
                        phase_in = PH_SR_CMD;
                        r.spi_valid = 1'b1;
                        r.spi_out_byte = snfcs_pkg::OP_RDSR;
                     end else if (phase_ff == PH_OPCODE && cmd_ff >= snfcs_pkg::CMD_PDOWN) begin
                        phase_in = PH_IDLE;
                        r.request_done = 1'b1;
                     end else if (phase_ff == PH_OPCODE ||
                                  32'(hidx_ff) + 1 < ADDR_BYTES) begin
                        hidx_in = (phase_ff == PH_OPCODE) ? 2'd0 : hidx_ff + 2'd1;
                        follows = (cmd_ff == snfcs_pkg::CMD_READ) ? (left_ff != 16'd0) :
                                  (cmd_ff == snfcs_pkg::CMD_WRITE) ? (page_ff != '0) : 1'b0;
                        last_hdr = (32'(hidx_in) + 1 >= ADDR_BYTES);
                        phase_in = PH_ADDR;
                        r.spi_valid = 1'b1;
                        r.spi_out_byte = addr_byte(cur_ff, hidx_in);
                        r.frame_end = last_hdr && !follows;
                     end else if (cmd_ff == snfcs_pkg::CMD_READ) begin
                        if (left_ff == 16'd0) begin
                           phase_in = PH_IDLE;
                           r.request_done = 1'b1;
                        end else begin
                           phase_in = PH_RDATA;
                           r.spi_valid = 1'b1;
                           r.spi_out_byte = snfcs_pkg::DUMMY_BYTE;
                           r.frame_end = (left_ff == 16'd1);
                        end
                     end else if (cmd_ff == snfcs_pkg::CMD_WRITE && page_ff != '0) begin
                        phase_in = PH_HOST;
                        r.need_host_byte = 1'b1;
                     end else begin
                        poll_in = '0; tick_in = '0; hidx_in = snfcs_pkg::GOAL_POST;
                        phase_in = PH_SR_CMD;
                        r.spi_valid = 1'b1;
                        r.spi_out_byte = snfcs_pkg::OP_RDSR;
                     end
                  end
                  PH_RDATA: begin
                     r.read_valid = 1'b1;
                     r.read_byte = item.response_byte;
                     left_in = (left_ff != 16'd0) ? left_ff - 16'd1 : left_ff;
                     cur_in = cur_ff + ADDRESS_BITS'(1);
                     if (left_in == 16'd0) begin
                        phase_in = PH_IDLE;
                        r.request_done = 1'b1;
                     end else begin
                        r.spi_valid = 1'b1;
                        r.spi_out_byte = snfcs_pkg::DUMMY_BYTE;
                        r.frame_end = (left_in == 16'd1);
                     end
                  end
                  PH_WDATA: begin
                     page_in = (page_ff != '0) ? page_ff - (PAGE_W+1)'(1) : page_ff;
                     left_in = (left_ff != 16'd0) ? left_ff - 16'd1 : left_ff;
                     cur_in = cur_ff + ADDRESS_BITS'(1);
                     if (page_in != '0) begin
                        phase_in = PH_HOST;
                        r.need_host_byte = 1'b1;
                     end else begin
                        poll_in = '0; tick_in = '0; hidx_in = snfcs_pkg::GOAL_POST;
                        phase_in = PH_SR_CMD;
                        r.spi_valid = 1'b1;
                        r.spi_out_byte = snfcs_pkg::OP_RDSR;
                     end
                  end
                  default: ;
               endcase
            end
         endcase
      end
   end

   // hold state and result while the result register cannot drain
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cmd_ff   <= '0;
         cur_ff   <= '0;
         left_ff  <= '0;
         page_ff  <= '0;
         hidx_ff  <= '0;
         poll_ff  <= '0;
         tick_ff  <= '0;
         result_valid <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         cur_ff   <= cur_in;
         left_ff  <= left_in;
         page_ff  <= page_in;
         hidx_ff  <= hidx_in;
         poll_ff  <= poll_in;
         tick_ff  <= tick_in;
         result_valid <= r.spi_valid | r.read_valid | r.need_host_byte |
                         r.request_done | r.timed_out;
      end
      if (advance) result <= r;
   end
endmodule

// ----- verif/snfcs_checker.sv -----
`timescale 1ns / 100ps

module snfcs_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [11:0] csr_data,
   output int          failures,
   output int          pending
);

   typedef enum logic [3:0] {
      SEQ_IDLE, SEQ_SR_CMD, SEQ_SR_DATA, SEQ_DELAY, SEQ_WREN,
      SEQ_OPCODE, SEQ_ADDR, SEQ_RDATA, SEQ_HOST, SEQ_WDATA
   } seq_phase_type;

   // listed from the top bit down so spi_valid lands on bit 0 of rsp_tdata
   typedef struct packed {
      logic       timed_out;
      logic       request_done;
      logic       need_host_byte;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       frame_end;
      logic [7:0] spi_out_byte;
      logic       spi_valid;
   } flash_step_type;

   seq_phase_type  seq_phase;
   logic [2:0]     cur_cmd;
   logic [23:0]    cursor;
   logic [15:0]    remaining;
   logic [8:0]     page_room;
   logic [1:0]     step_index;
   logic [11:0]    busy_polls;
   logic [7:0]     ticks_waited;
   logic [11:0]    poll_limit;
   logic [7:0]     poll_interval;

   flash_step_type expected_steps[$];

   function automatic void put_byte(ref flash_step_type s, input logic [7:0] b,
                                    input logic fe);
      s.spi_valid    = 1'b1;
      s.spi_out_byte = b;
      s.frame_end    = fe;
   endfunction

   function automatic void begin_busy_wait(ref flash_step_type s, input logic [1:0] goal);
      busy_polls   = '0;
      ticks_waited = '0;
      step_index   = goal;
      seq_phase    = SEQ_SR_CMD;
      put_byte(s, snfcs_pkg::OP_RDSR, 1'b0);
   endfunction

   function automatic void fit_page();
      logic [8:0] room;
      room = 9'd256 - {1'b0, cursor[7:0]};
      page_room = (remaining < {7'd0, room}) ? remaining[8:0] : room;
   endfunction

   function automatic logic more_data();
      if (cur_cmd == snfcs_pkg::CMD_READ) return remaining != 0;
      if (cur_cmd == snfcs_pkg::CMD_WRITE) return page_room != 0;
      return 1'b0;
   endfunction

   function automatic void put_address(ref flash_step_type s);
      logic [7:0] b;
      case (step_index)
         2'd0:    b = cursor[23:16];
         2'd1:    b = cursor[15:8];
         default: b = cursor[7:0];
      endcase
      seq_phase = SEQ_ADDR;
      put_byte(s, b, (step_index == 2'd2) && !more_data());
   endfunction

   function automatic void close_request(ref flash_step_type s);
      seq_phase      = SEQ_IDLE;
      s.request_done = 1'b1;
   endfunction

   function automatic void resume_after_wait(ref flash_step_type s);
      if (step_index == snfcs_pkg::GOAL_PRE) begin
         if (cur_cmd == snfcs_pkg::CMD_READ) begin
            seq_phase = SEQ_OPCODE;
            put_byte(s, snfcs_pkg::OP_READ, 1'b0);
         end else begin
            seq_phase = SEQ_WREN;
            put_byte(s, snfcs_pkg::OP_WREN, 1'b1);
         end
      end else if (step_index == snfcs_pkg::GOAL_WREN) begin
         seq_phase = SEQ_OPCODE;
         if (cur_cmd == snfcs_pkg::CMD_WRITE) put_byte(s, snfcs_pkg::OP_PROGRAM, 1'b0);
         else if (cur_cmd == snfcs_pkg::CMD_SECTOR) put_byte(s, snfcs_pkg::OP_SECTOR, 1'b0);
         else put_byte(s, snfcs_pkg::OP_CHIP, 1'b1);
      end else if (cur_cmd == snfcs_pkg::CMD_WRITE && remaining != 0) begin
         fit_page();
         begin_busy_wait(s, snfcs_pkg::GOAL_PRE);
      end else begin
         close_request(s);
      end
   endfunction

   function automatic void take_response(ref flash_step_type s, input logic [7:0] rb);
      case (seq_phase)
         SEQ_SR_CMD: begin
            seq_phase = SEQ_SR_DATA;
            put_byte(s, snfcs_pkg::DUMMY_BYTE, 1'b1);
         end
         SEQ_SR_DATA: begin
            if (!rb[0]) begin
               resume_after_wait(s);
            end else if (busy_polls >= poll_limit) begin
               s.timed_out = 1'b1;
               resume_after_wait(s);
            end else begin
               busy_polls   = busy_polls + 1'b1;
               ticks_waited = '0;
               if (poll_interval == 0) begin
                  seq_phase = SEQ_SR_CMD;
                  put_byte(s, snfcs_pkg::OP_RDSR, 1'b0);
               end else begin
                  seq_phase = SEQ_DELAY;
               end
            end
         end
         SEQ_WREN: begin_busy_wait(s, snfcs_pkg::GOAL_WREN);
         SEQ_OPCODE: begin
            if (cur_cmd == snfcs_pkg::CMD_CHIP) begin_busy_wait(s, snfcs_pkg::GOAL_POST);
            else if (cur_cmd >= snfcs_pkg::CMD_PDOWN) close_request(s);
            else begin
               step_index = 2'd0;
               put_address(s);
            end
         end
         SEQ_ADDR: begin
            if (step_index < 2'd2) begin
               step_index = step_index + 1'b1;
               put_address(s);
            end else if (cur_cmd == snfcs_pkg::CMD_READ) begin
               if (remaining == 0) close_request(s);
               else begin
                  seq_phase = SEQ_RDATA;
                  put_byte(s, snfcs_pkg::DUMMY_BYTE, remaining == 1);
               end
            end else if (cur_cmd == snfcs_pkg::CMD_WRITE && page_room != 0) begin
               seq_phase        = SEQ_HOST;
               s.need_host_byte = 1'b1;
            end else begin
               begin_busy_wait(s, snfcs_pkg::GOAL_POST);
            end
         end
         SEQ_RDATA: begin
            s.read_valid = 1'b1;
            s.read_byte  = rb;
            if (remaining != 0) remaining = remaining - 1'b1;
            cursor = cursor + 1'b1;
            if (remaining == 0) close_request(s);
            else put_byte(s, snfcs_pkg::DUMMY_BYTE, remaining == 1);
         end
         SEQ_WDATA: begin
            if (page_room != 0) page_room = page_room - 1'b1;
            if (remaining != 0) remaining = remaining - 1'b1;
            cursor = cursor + 1'b1;
            if (page_room != 0) begin
               seq_phase        = SEQ_HOST;
               s.need_host_byte = 1'b1;
            end else begin
               begin_busy_wait(s, snfcs_pkg::GOAL_POST);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic sequence_item(input snfcs_pkg::oper_type op,
                                          input logic [2:0] cmd,
                                          input logic [23:0] addr, input logic [15:0] cnt,
                                          input logic [7:0] hb, input logic [7:0] rb,
                                          output flash_step_type s);
      s = '0;
      case (op)
         snfcs_pkg::OPER_REQUEST: begin
            if (seq_phase == SEQ_IDLE && cmd <= snfcs_pkg::CMD_WAKE) begin
               cur_cmd   = cmd;
               cursor    = addr;
               remaining = cnt;
               if (cmd == snfcs_pkg::CMD_PDOWN || cmd == snfcs_pkg::CMD_WAKE) begin
                  seq_phase = SEQ_OPCODE;
                  put_byte(s, (cmd == snfcs_pkg::CMD_PDOWN) ? snfcs_pkg::OP_PDOWN :
                           snfcs_pkg::OP_WAKE, 1'b1);
               end else begin
                  if (cmd == snfcs_pkg::CMD_WRITE) fit_page();
                  begin_busy_wait(s, snfcs_pkg::GOAL_PRE);
               end
            end
         end
         snfcs_pkg::OPER_HOST: begin
            if (seq_phase == SEQ_HOST) begin
               seq_phase = SEQ_WDATA;
               put_byte(s, hb, page_room == 1);
            end
         end
         snfcs_pkg::OPER_RESPONSE: take_response(s, rb);
         default: begin
            if (seq_phase == SEQ_DELAY) begin
               if (ticks_waited != 8'hFF) ticks_waited = ticks_waited + 1'b1;
               if (ticks_waited >= poll_interval) begin
                  seq_phase = SEQ_SR_CMD;
                  put_byte(s, snfcs_pkg::OP_RDSR, 1'b0);
               end
            end
         end
      endcase
      return s.spi_valid || s.read_valid || s.need_host_byte || s.request_done
             || s.timed_out;
   endfunction

   // response_byte sits above command, address, count and host byte; the zero fill drops
   always @(posedge clock) begin
      flash_step_type want, got;
      logic [58:0]    fields;
      if (reset) begin
         cur_cmd       = '0;
         cursor        = '0;
         remaining     = '0;
         page_room     = '0;
         step_index    = '0;
         busy_polls    = '0;
         ticks_waited  = '0;
         poll_limit    = snfcs_pkg::POLL_LIMIT_RESET;
         poll_interval = snfcs_pkg::POLL_INTERVAL_RESET;
         seq_phase     = SEQ_IDLE;
         expected_steps.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == snfcs_pkg::CSR_POLL_LIMIT) poll_limit = csr_data;
            else poll_interval = csr_data[7:0];
         end
         if (req_tvalid && req_tready) begin
            fields = req_tdata[58:0];
            if (sequence_item(snfcs_pkg::oper_type'(req_tuser), fields[2:0], fields[26:3],
                              fields[42:27], fields[50:43], fields[58:51], want))
               expected_steps.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[21:0];
            if (expected_steps.size() == 0) begin
               $error("unexpected result item %h", rsp_tdata);
               failures++;
            end else begin
               want = expected_steps.pop_front();
               if (got.spi_valid !== want.spi_valid) begin
                  $error("spi_valid exp %0d got %0d", want.spi_valid, got.spi_valid);
                  failures++;
               end
               if (got.spi_out_byte !== want.spi_out_byte) begin
                  $error("spi_out_byte exp %h got %h", want.spi_out_byte, got.spi_out_byte);
                  failures++;
               end
               if (got.frame_end !== want.frame_end) begin
                  $error("frame_end exp %0d got %0d", want.frame_end, got.frame_end);
                  failures++;
               end
               if (got.read_valid !== want.read_valid) begin
                  $error("read_valid exp %0d got %0d", want.read_valid, got.read_valid);
                  failures++;
               end
               if (got.read_byte !== want.read_byte) begin
                  $error("read_byte exp %h got %h", want.read_byte, got.read_byte);
                  failures++;
               end
               if (got.need_host_byte !== want.need_host_byte) begin
                  $error("need_host_byte exp %0d got %0d", want.need_host_byte,
                         got.need_host_byte);
                  failures++;
               end
               if (got.request_done !== want.request_done) begin
                  $error("request_done exp %0d got %0d", want.request_done,
                         got.request_done);
                  failures++;
               end
               if (got.timed_out !== want.timed_out) begin
                  $error("timed_out exp %0d got %0d", want.timed_out, got.timed_out);
                  failures++;
               end
               if (rsp_tlast !== 1'b1) begin
                  $error("last exp 1 got %0d", rsp_tlast);
                  failures++;
               end
               if (rsp_tdata[23:22] !== 2'b00) begin
                  $error("zero fill exp 0 got %0d", rsp_tdata[23:22]);
                  failures++;
               end
            end
         end
      end
      pending <= expected_steps.size();
   end

   initial begin
      failures = 0;
      pending  = 0;
   end

endmodule

// ----- verif/tb_spi_nor_flash_command_sequencer_core.sv -----
`timescale 1ns / 100ps

module tb_spi_nor_flash_command_sequencer_core;

   localparam int QUIET_LIMIT     = 4000;
   localparam int FLOW_ITEM_LIMIT = 50000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [11:0] csr_data;
   int          failures;
   int          pending;

   int spi_bytes_seen, host_wants_seen, requests_done, timeouts_seen;
   int responses_sent, host_bytes_sent, items_sent, flows_run;
   int burst_left, busy_pct, quiet_cycles, stall_mode, stall_phase;

   spi_nor_flash_command_sequencer_core DUT (.*);

   snfcs_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // count what the block asks for so the stimulus can answer it
   always @(posedge clock) begin
      if (reset) begin
         spi_bytes_seen  <= 0;
         host_wants_seen <= 0;
         requests_done   <= 0;
         timeouts_seen   <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (rsp_tdata[0])  spi_bytes_seen  <= spi_bytes_seen + 1;
         if (rsp_tdata[19]) host_wants_seen <= host_wants_seen + 1;
         if (rsp_tdata[20]) requests_done   <= requests_done + 1;
         if (rsp_tdata[21]) timeouts_seen   <= timeouts_seen + 1;
      end
   end

   // receiver stall pattern: always ready, alternate, or random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         stall_mode  <= 0;
         stall_phase <= 0;
      end else begin
         stall_phase <= stall_phase + 1;
         if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= stall_phase[0];
            default: rsp_tready <= ($urandom_range(0, 9) < 6);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic send_item(input snfcs_pkg::oper_type op, input logic [2:0] cmd,
                            input logic [23:0] addr, input logic [15:0] cnt,
                            input logic [7:0] hb, input logic [7:0] rb);
      logic [58:0] packed_fields;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
      end
      burst_left--;
      packed_fields = {rb, hb, cnt, addr, cmd};
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {5'd0, packed_fields};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic write_register(input logic idx, input logic [11:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // stray ticks and unknown commands; the block drops unknown commands, and ticks outside a poll delay
   task automatic send_noise();
      case ($urandom_range(0, 1))
         0: send_item(snfcs_pkg::OPER_TICK, 3'($urandom), 24'($urandom), 16'($urandom),
                      8'd0, 8'd0);
         default: send_item(snfcs_pkg::OPER_REQUEST, 3'($urandom_range(6, 7)),
                            24'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
      endcase
   endtask

   // drive one request and answer every byte it sends until it reports done
   task automatic run_request(input logic [2:0] cmd, input logic [23:0] addr,
                              input logic [15:0] cnt, input bit poke_busy);
      int done_mark;
      int resp_owed, host_owed;
      int start_items;
      logic [7:0] status;
      done_mark       = requests_done;
      responses_sent  = spi_bytes_seen;
      host_bytes_sent = host_wants_seen;
      start_items     = items_sent;
      send_item(snfcs_pkg::OPER_REQUEST, cmd, addr, cnt, 8'($urandom), 8'($urandom));
      flows_run++;
      if (poke_busy)
         send_item(snfcs_pkg::OPER_REQUEST, 3'($urandom_range(0, 5)), 24'($urandom),
                   16'($urandom), 8'd0, 8'd0);
      while (requests_done == done_mark) begin
         if (items_sent - start_items > FLOW_ITEM_LIMIT) begin
            $error("request never finished");
            $display("Regression FAIL");
            $finish;
         end
         resp_owed = spi_bytes_seen - responses_sent;
         host_owed = host_wants_seen - host_bytes_sent;
         if ($urandom_range(0, 19) == 0) begin
            send_noise();
         end else if (resp_owed > 0 && (host_owed == 0 || $urandom_range(0, 1))) begin
            status    = 8'($urandom);
            status[0] = ($urandom_range(0, 99) < busy_pct);
            responses_sent++;
            send_item(snfcs_pkg::OPER_RESPONSE, 3'($urandom), 24'($urandom), 16'($urandom),
                      8'($urandom), status);
         end else if (host_owed > 0) begin
            host_bytes_sent++;
            send_item(snfcs_pkg::OPER_HOST, 3'($urandom), 24'($urandom), 16'($urandom),
                      8'($urandom), 8'($urandom));
         end else begin
            send_item(snfcs_pkg::OPER_TICK, 3'd0, 24'd0, 16'd0, 8'd0, 8'd0);
         end
      end
   endtask

   task automatic run_random_request();
      logic [2:0]  cmd;
      logic [23:0] addr;
      logic [15:0] cnt;
      int          pick;
      pick = $urandom_range(0, 9);
      cmd  = (pick < 4) ? snfcs_pkg::CMD_WRITE : (pick < 7) ? snfcs_pkg::CMD_READ :
             3'($urandom_range(2, 5));
      addr = 24'($urandom);
      if ($urandom_range(0, 2) == 0) addr[7:0] = 8'($urandom_range(240, 255));
      cnt = 16'($urandom_range(0, 12));
      if (cmd == snfcs_pkg::CMD_WRITE && $urandom_range(0, 9) == 0)
         cnt = 16'($urandom_range(13, 300));
      if (cmd >= snfcs_pkg::CMD_SECTOR) cnt = 16'($urandom);
      run_request(cmd, addr, cnt, $urandom_range(0, 7) == 0);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = snfcs_pkg::OPER_TICK;
      csr_valid  = 1'b0;
      csr_index  = snfcs_pkg::CSR_POLL_LIMIT;
      csr_data   = '0;
      burst_left = 0;
      busy_pct   = 30;
      items_sent = 0;
      flows_run  = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ignored items at idle, then every command and the corner requests
      send_item(snfcs_pkg::OPER_HOST, 3'd0, 24'd0, 16'd0, 8'hFF, 8'h00);
      send_item(snfcs_pkg::OPER_RESPONSE, 3'd0, 24'd0, 16'd0, 8'h00, 8'hFF);
      send_item(snfcs_pkg::OPER_TICK, 3'd0, 24'd0, 16'd0, 8'd0, 8'd0);
      send_item(snfcs_pkg::OPER_REQUEST, 3'd6, 24'hFFFFFF, 16'hFFFF, 8'hFF, 8'hFF);
      send_item(snfcs_pkg::OPER_REQUEST, 3'd7, 24'h000000, 16'h0000, 8'h00, 8'h00);
      run_request(snfcs_pkg::CMD_READ, 24'hFFFFFE, 16'd3, 1'b1);
      run_request(snfcs_pkg::CMD_READ, 24'h000000, 16'd0, 1'b0);
      run_request(snfcs_pkg::CMD_WRITE, 24'h123456, 16'd0, 1'b0);
      run_request(snfcs_pkg::CMD_WRITE, 24'h0000F0, 16'd20, 1'b0);
      run_request(snfcs_pkg::CMD_WRITE, 24'hFFFFFF, 16'd2, 1'b0);
      run_request(snfcs_pkg::CMD_SECTOR, 24'hFFFFFF, 16'hFFFF, 1'b0);
      run_request(snfcs_pkg::CMD_CHIP, 24'h000000, 16'h0000, 1'b0);
      run_request(snfcs_pkg::CMD_PDOWN, 24'hA5A5A5, 16'h5A5A, 1'b0);
      run_request(snfcs_pkg::CMD_WAKE, 24'h5A5A5A, 16'hA5A5, 1'b0);
      settle();

      // poll limit zero: first busy answer times out; interval zero polls at once
      write_register(snfcs_pkg::CSR_POLL_LIMIT, 12'd0);
      write_register(snfcs_pkg::CSR_POLL_INTERVAL, 12'd0);
      busy_pct = 50;
      repeat (6) run_random_request();
      settle();

      write_register(snfcs_pkg::CSR_POLL_LIMIT, 12'd4095);
      write_register(snfcs_pkg::CSR_POLL_INTERVAL, 12'd255);
      busy_pct = 5;
      repeat (3) run_random_request();
      settle();

      write_register(snfcs_pkg::CSR_POLL_LIMIT, 12'd1);
      write_register(snfcs_pkg::CSR_POLL_INTERVAL, 12'd1);
      busy_pct = 40;
      repeat (6) run_random_request();
      settle();

      while (items_sent < 550) begin
         write_register(snfcs_pkg::CSR_POLL_LIMIT, 12'($urandom_range(0, 6)));
         write_register(snfcs_pkg::CSR_POLL_INTERVAL, 12'($urandom_range(0, 4)));
         busy_pct = $urandom_range(10, 50);
         repeat (5) run_random_request();
         settle();
      end

      $display("Ran %0d requests in %0d input items under several poll settings,", flows_run,
               items_sent);
      $display("with %0d busy timeouts and random sender gaps and receiver stalls.",
               timeouts_seen);
      if (failures == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
